// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that report through $error.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clk edge outside of reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked on every clk edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/blr_pkg.sv =====
// ---------------------------------------------------------------------------
// blr_pkg
// Shared constants for the bounded array list engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int MODE_W  = 2;
  localparam int POS_W   = 10;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 11;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/bounded_array_list_engine.sv =====
// ---------------------------------------------------------------------------
// bounded_array_list_engine
// Ordered list of elements in a single-port-read store with a running count.
//
//   channel  dir  handshake           words
//   in       in   in_valid/in_stall   mode, position, value_in
//   out      out  out_valid/out_stall value_out, status, count
//
// Append and error results go from the result state to the output register;
// read-at and pop pass the read state first. Remove-at also walks the
// store after the read, one entry per cycle through its one read port.
// Reset clears the count and out_valid; the store needs no clearing pass.
// A stalled result holds in the output register; one more word is taken in
// and waits in the sequencer, then in_stall holds until the register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_array_list_engine #(
  parameter int DEPTH      = blr_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = blr_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [blr_pkg::MODE_W-1:0]   mode,
  input  wire logic [blr_pkg::POS_W-1:0]    position,
  input  wire logic [blr_pkg::WORD_W-1:0]   value_in,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [blr_pkg::WORD_W-1:0]   value_out,
  output logic                              status,
  output logic      [blr_pkg::COUNT_W-1:0]  count
);

  import blr_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_rdata;

  blr_ctrl #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .position  (position),
    .value_in  (value_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_out (value_out),
    .status    (status),
    .count     (count),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  blr_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/blr_mem.sv =====
// ---------------------------------------------------------------------------
// blr_mem
// Element store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blr_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/blr_ctrl.sv =====
// ---------------------------------------------------------------------------
// blr_ctrl
// Request sequencer: checks, count update, store accesses, shift walk and
// result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blr_ctrl #(
  parameter int DEPTH      = 1024,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [blr_pkg::MODE_W-1:0]   mode,
  input  wire logic [blr_pkg::POS_W-1:0]    position,
  input  wire logic [blr_pkg::WORD_W-1:0]   value_in,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [blr_pkg::WORD_W-1:0]   value_out,
  output logic                              status,
  output logic      [blr_pkg::COUNT_W-1:0]  count,
  output logic                              mem_we,
  output logic      [$clog2(DEPTH)-1:0]     mem_waddr,
  output logic      [ELEM_WIDTH-1:0]        mem_wdata,
  output logic      [$clog2(DEPTH)-1:0]     mem_raddr,
  input  wire logic [ELEM_WIDTH-1:0]        mem_rdata
);

  import blr_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]        state;
  logic [MODE_W-1:0] op;
  logic [CNT_W-1:0]  elem_count;
  logic [AW-1:0]     wr_ptr;
  logic [WORD_W-1:0] st_value;
  logic              st_status;

  logic              accept;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic              idx_ok;
  logic              full;
  logic              empty;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  wr_inc;
  logic [WORD_W-1:0] rd_word;
  logic [ELEM_WIDTH-1:0] elem_in;

  generate
    if (ELEM_WIDTH >= WORD_W) begin : g_wide
      assign rd_word = mem_rdata[WORD_W-1:0];
      assign elem_in = ELEM_WIDTH'(value_in);
    end else begin : g_narrow
      assign rd_word = WORD_W'(mem_rdata);
      assign elem_in = value_in[ELEM_WIDTH-1:0];
    end
  endgenerate

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign pos_c   = CMP_W'(position);
  assign cnt_c   = CMP_W'(elem_count);
  assign idx_ok  = (pos_c < cnt_c);
  assign full    = (elem_count == CNT_W'(DEPTH));
  assign empty   = (elem_count == '0);
  assign cnt_dec = elem_count - 1'b1;
  assign wr_inc  = CNT_W'(wr_ptr) + 1'b1;

  always_comb begin
    unique case (state)
      S_IDLE: begin
        if (mode == MODE_POP) begin
          mem_raddr = cnt_dec[AW-1:0];
        end else begin
          mem_raddr = pos_c[AW-1:0];
        end
      end
      S_READ:  mem_raddr = wr_ptr + 1'b1;
      S_SHIFT: mem_raddr = wr_ptr + AW'(2);
      default: mem_raddr = '0;
    endcase
  end

  // shift walk: write k with what was read at k+1, read k+2 behind it
  assign mem_we    = (accept && (mode == MODE_APPEND) && !full) || (state == S_SHIFT);
  assign mem_waddr = (state == S_SHIFT) ? wr_ptr : elem_count[AW-1:0];
  assign mem_wdata = (state == S_SHIFT) ? mem_rdata : elem_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      elem_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= mode;
            wr_ptr    <= pos_c[AW-1:0];
            st_value  <= '0;
            unique case (mode)
              MODE_APPEND: begin
                if (full) begin
                  st_status <= 1'b1;
                end else begin
                  st_status  <= 1'b0;
                  elem_count <= elem_count + 1'b1;
                end
                state <= S_OUT;
              end
              MODE_READ: begin
                if (idx_ok) begin
                  st_status <= 1'b0;
                  state     <= S_READ;
                end else begin
                  st_status <= 1'b1;
                  state     <= S_OUT;
                end
              end
              MODE_POP: begin
                if (empty) begin
                  st_status <= 1'b1;
                  state     <= S_OUT;
                end else begin
                  st_status  <= 1'b0;
                  elem_count <= cnt_dec;
                  state      <= S_READ;
                end
              end
              MODE_REMOVE: begin
                if (idx_ok) begin
                  st_status  <= 1'b0;
                  elem_count <= cnt_dec;
                  state      <= S_READ;
                end else begin
                  st_status <= 1'b1;
                  state     <= S_OUT;
                end
              end
              default: begin
                st_status <= 1'b0;
                state     <= S_OUT;
              end
            endcase
          end
        end
        S_READ: begin
          st_value <= rd_word;
          if ((op == MODE_REMOVE) && (CNT_W'(wr_ptr) < elem_count)) begin
            state <= S_SHIFT;
          end else begin
            state <= S_OUT;
          end
        end
        S_SHIFT: begin
          wr_ptr <= wr_ptr + 1'b1;
          if (!(wr_inc < elem_count)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            value_out <= st_value;
            status    <= st_status;
            count     <= COUNT_W'(elem_count);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/blr_checker.sv =====
// ---------------------------------------------------------------------------
// blr_checker
// Port-level checks on the bounded array list engine, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module blr_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [blr_pkg::WORD_W-1:0]   value_out,
  input wire logic                         status,
  input wire logic [blr_pkg::COUNT_W-1:0]  count
);

  // one request in flight: an accepted word closes the input
  `ASSERT_CLK(a_one_in_flight, in_valid && !in_stall |=> in_stall)

  // errors carry no element
  `ASSERT_CLK(a_err_zero, out_valid && status |-> value_out == '0)

  // stalled result holds
  `ASSERT_CLK(a_out_hold, out_valid & out_stall |=> out_valid & $stable({value_out, status, count}))

  // reset empties the output register
  `ASSERT_CLK_ALWAYS(a_rst_out, rst |=> !out_valid)

endmodule

bind bounded_array_list_engine blr_checker u_blr_checker (.*);

`default_nettype wire
